// ----- design/wsdf_pkg.sv -----
package wsdf_pkg;

    // result classes
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_UNEXP_CONT  = 3'd1,
        ERR_EXPECT_CONT = 3'd2,
        ERR_RSVD_OPCODE = 3'd3,
        ERR_UNMASKED    = 3'd4,
        ERR_LEN_BIG     = 3'd5,
        ERR_HALTED      = 3'd6
    } err_t;

    // frame opcodes
    localparam logic [3:0] OP_CONT   = 4'd0;
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    // 7-bit length codes
    localparam logic [6:0] LEN7_MAX   = 7'd125;
    localparam logic [6:0] LEN7_EXT16 = 7'd126;

    // extended length byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    // queue between parser and output stage
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified byte on its way to the output stage
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [3:0]  opcode;
        logic        fin;
        logic        last;
        err_t        err;
        logic        key_wr;
        logic [1:0]  idx;
    } q_entry_t;

    function automatic logic is_start_opcode(input logic [3:0] op);
        return (op == OP_TEXT) || (op == OP_BINARY) || (op == OP_CLOSE) ||
               (op == OP_PING) || (op == OP_PONG);
    endfunction

endpackage

// ----- design/wsdf_front.sv -----
module wsdf_front
    import wsdf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       q_full,
    output logic       q_push,
    output q_entry_t   q_data
);

    typedef enum logic [4:0] {
        PH_OPCODE  = 5'b00001,
        PH_LEN     = 5'b00010,
        PH_LEN_EXT = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        in_frag_reg, in_frag_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [63:0] length_reg, length_next;
    logic [3:0]  left_reg, left_next;
    logic [1:0]  idx_reg, idx_next;
    logic        halted_reg, halted_next;

    logic [63:0] len_shift;
    logic [3:0]  left_dec;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    assign len_shift = {length_reg[55:0], s_byte_in};
    assign left_dec  = (left_reg != 4'd0) ? left_reg - 4'd1 : 4'd0;

    // per-byte parse and classification
    always_comb begin
        phase_next   = phase_reg;
        in_frag_next = in_frag_reg;
        fin_next     = fin_reg;
        opcode_next  = opcode_reg;
        length_next  = length_reg;
        left_next    = left_reg;
        idx_next     = idx_reg;
        halted_next  = halted_reg;

        q_data.kind   = KIND_HEADER;
        q_data.data   = s_byte_in;
        q_data.opcode = opcode_reg;
        q_data.fin    = fin_reg;
        q_data.last   = 1'b0;
        q_data.err    = ERR_NONE;
        q_data.key_wr = 1'b0;
        q_data.idx    = idx_reg;

        if (halted_reg) begin
            q_data.kind = KIND_ERROR;
            q_data.err  = ERR_HALTED;
        end else begin
            unique case (phase_reg)
                PH_OPCODE: begin
                    fin_next      = s_byte_in[7];
                    opcode_next   = s_byte_in[3:0];
                    q_data.fin    = s_byte_in[7];
                    q_data.opcode = s_byte_in[3:0];
                    phase_next    = PH_LEN;
                    if (s_byte_in[3:0] == OP_CONT) begin
                        if (!in_frag_reg) begin
                            q_data.kind = KIND_ERROR;
                            q_data.err  = ERR_UNEXP_CONT;
                            halted_next = 1'b1;
                        end
                    end else if (is_start_opcode(s_byte_in[3:0])) begin
                        if (in_frag_reg) begin
                            q_data.kind = KIND_ERROR;
                            q_data.err  = ERR_EXPECT_CONT;
                            halted_next = 1'b1;
                        end else if (!s_byte_in[7]) begin
                            in_frag_next = 1'b1;
                        end
                    end else begin
                        q_data.kind = KIND_ERROR;
                        q_data.err  = ERR_RSVD_OPCODE;
                        halted_next = 1'b1;
                    end
                end
                PH_LEN: begin
                    if (!s_byte_in[7]) begin
                        q_data.kind = KIND_ERROR;
                        q_data.err  = ERR_UNMASKED;
                        halted_next = 1'b1;
                    end else begin
                        idx_next = 2'd0;
                        if (s_byte_in[6:0] <= LEN7_MAX) begin
                            length_next = {57'd0, s_byte_in[6:0]};
                            phase_next  = PH_KEY;
                        end else if (s_byte_in[6:0] == LEN7_EXT16) begin
                            length_next = 64'd0;
                            left_next   = EXT16_BYTES;
                            phase_next  = PH_LEN_EXT;
                        end else begin
                            length_next = 64'd0;
                            left_next   = EXT64_BYTES;
                            phase_next  = PH_LEN_EXT;
                        end
                    end
                end
                PH_LEN_EXT: begin
                    length_next = len_shift;
                    left_next   = left_dec;
                    if (left_dec == 4'd0) begin
                        if (len_shift[63]) begin
                            q_data.kind = KIND_ERROR;
                            q_data.err  = ERR_LEN_BIG;
                            halted_next = 1'b1;
                        end else begin
                            phase_next = PH_KEY;
                        end
                    end
                end
                PH_KEY: begin
                    q_data.key_wr = 1'b1;
                    idx_next      = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        if (length_reg == 64'd0) begin
                            q_data.last = 1'b1;
                            phase_next  = PH_OPCODE;
                            if (fin_reg) begin
                                in_frag_next = 1'b0;
                            end
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    // length counts down the bytes still to come
                    q_data.kind = KIND_PAYLOAD;
                    idx_next    = idx_reg + 2'd1;
                    length_next = length_reg - 64'd1;
                    if (length_reg == 64'd1) begin
                        q_data.last = 1'b1;
                        phase_next  = PH_OPCODE;
                        if (fin_reg) begin
                            in_frag_next = 1'b0;
                        end
                    end
                end
                default: begin
                    phase_next = PH_OPCODE;
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_OPCODE;
            in_frag_reg <= 1'b0;
            fin_reg     <= 1'b0;
            opcode_reg  <= 4'd0;
            left_reg    <= 4'd0;
            idx_reg     <= 2'd0;
            halted_reg  <= 1'b0;
        end else if (q_push) begin
            phase_reg   <= phase_next;
            in_frag_reg <= in_frag_next;
            fin_reg     <= fin_next;
            opcode_reg  <= opcode_next;
            left_reg    <= left_next;
            idx_reg     <= idx_next;
            halted_reg  <= halted_next;
        end
    end

    // length register, not reset
    always_ff @(posedge aclk) begin
        if (q_push) begin
            length_reg <= length_next;
        end
    end

endmodule

// ----- design/wsdf_queue.sv -----
module wsdf_queue
    import wsdf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     q_valid,
    output q_entry_t pop_data
);

    q_entry_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;

    // pointer and fill tracking
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/wsdf_back.sv -----
module wsdf_back
    import wsdf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  q_entry_t   q_data,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_out,
    output logic [3:0] m_frame_opcode,
    output logic       m_message_final,
    output logic       m_last_of_frame,
    output logic [2:0] m_error_code
);

    logic [7:0] key_reg [4];
    logic       valid_reg;
    kind_t      kind_reg;
    logic [7:0] data_reg, data_next;
    logic [3:0] opcode_reg;
    logic       fin_reg;
    logic       last_reg;
    err_t       err_reg;

    assign q_pop = q_valid && (!valid_reg || m_ready);

    // unmask payload bytes, zero for everything else
    assign data_next = (q_data.kind == KIND_PAYLOAD) ? (q_data.data ^ key_reg[q_data.idx])
                                                     : 8'd0;

    // masking key capture
    always_ff @(posedge aclk) begin
        if (q_pop && q_data.key_wr) begin
            key_reg[q_data.idx] <= q_data.data;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg   <= q_data.kind;
            data_reg   <= data_next;
            opcode_reg <= q_data.opcode;
            fin_reg    <= q_data.fin;
            last_reg   <= q_data.last;
            err_reg    <= q_data.err;
        end
    end

    assign m_valid         = valid_reg;
    assign m_kind          = kind_reg;
    assign m_data_out      = data_reg;
    assign m_frame_opcode  = opcode_reg;
    assign m_message_final = fin_reg;
    assign m_last_of_frame = last_reg;
    assign m_error_code    = err_reg;

endmodule

// ----- design/websocket_frame_deframer_unit.sv -----
// path: an accepted byte is written into the queue, then popped into the output register
// throughput: one byte per cycle while the queue is not full, set by the combinational parser
// update with its 64-bit length countdown and compare; m_ready low can stall the input
// reset: synchronous active-low aresetn clears the parser phase, fragment and halt flags,
// the queue and the output valid; no clearing pass
module websocket_frame_deframer_unit
    import wsdf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_out,
    output logic [3:0] m_frame_opcode,
    output logic       m_message_final,
    output logic       m_last_of_frame,
    output logic [2:0] m_error_code
);

    logic     q_full;
    logic     q_push;
    q_entry_t q_in;
    logic     q_pop;
    logic     q_valid;
    q_entry_t q_out;

    // header parser and byte classifier
    wsdf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_byte_in (s_byte_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // decoupling queue
    wsdf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .pop_data  (q_out)
    );

    // key capture, unmasking and result register
    wsdf_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_data          (q_out),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_data_out      (m_data_out),
        .m_frame_opcode  (m_frame_opcode),
        .m_message_final (m_message_final),
        .m_last_of_frame (m_last_of_frame),
        .m_error_code    (m_error_code)
    );

endmodule

// ----- bench/tb_websocket_frame_deframer_unit.sv -----
module tb_websocket_frame_deframer_unit;
    import wsdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_BYTES = 1000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_LEN,
        PH_LEN_EXT,
        PH_KEY,
        PH_PAYLOAD
    } parse_phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
        err_t       err;
    } deframe_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_byte_in = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_kind;
    logic [7:0] m_data_out;
    logic [3:0] m_frame_opcode;
    logic       m_message_final;
    logic       m_last_of_frame;
    logic [2:0] m_error_code;

    // stream bytes waiting for the driver, results waiting for the monitor
    logic [7:0]      stream_bytes[$];
    deframe_result_t expected_results[$];

    int n_total = 0;
    int n_sent = 0;
    int n_fail = 0;
    int idle_cycles = 0;
    logic s_fire = 1'b0;

    // parser state mirror
    parse_phase_t   pr_phase = PH_OPCODE;
    logic           pr_in_frag = 1'b0;
    logic           pr_fin = 1'b0;
    logic [3:0]     pr_opcode = 4'h0;
    logic [63:0]    pr_len = 64'd0;
    logic [3:0]     pr_len_left = 4'd0;
    logic [7:0]     pr_key[4] = '{8'h00, 8'h00, 8'h00, 8'h00};
    logic [1:0]     pr_key_idx = 2'd0;
    logic [63:0]    pr_done = 64'd0;
    logic           pr_halted = 1'b0;

    websocket_frame_deframer_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_data_out      (m_data_out),
        .m_frame_opcode  (m_frame_opcode),
        .m_message_final (m_message_final),
        .m_last_of_frame (m_last_of_frame),
        .m_error_code    (m_error_code)
    );

    always #5 aclk = ~aclk;

    // frame completion: back to the opcode byte, a final frame ends the message
    function automatic void close_frame();
        pr_phase = PH_OPCODE;
        if (pr_fin) begin
            pr_in_frag = 1'b0;
        end
    endfunction

    // advance the parser mirror by one byte and return the result it causes
    function automatic deframe_result_t deframe_byte(input logic [7:0] b);
        deframe_result_t r;
        kind_t      kind;
        logic [7:0] data;
        logic       last;
        err_t       err;
        kind = KIND_HEADER;
        data = 8'h00;
        last = 1'b0;
        err = ERR_NONE;
        if (pr_halted) begin
            err = ERR_HALTED;
        end else begin
            case (pr_phase)
                PH_OPCODE: begin
                    pr_fin = b[7];
                    pr_opcode = b[3:0];
                    if (pr_opcode == OP_CONT) begin
                        if (!pr_in_frag) err = ERR_UNEXP_CONT;
                    end else if (pr_opcode == OP_TEXT || pr_opcode == OP_BINARY ||
                                 pr_opcode == OP_CLOSE || pr_opcode == OP_PING ||
                                 pr_opcode == OP_PONG) begin
                        if (pr_in_frag) err = ERR_EXPECT_CONT;
                        else if (!pr_fin) pr_in_frag = 1'b1;
                    end else begin
                        err = ERR_RSVD_OPCODE;
                    end
                    pr_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (!b[7]) begin
                        err = ERR_UNMASKED;
                    end else begin
                        pr_done = 64'd0;
                        pr_key_idx = 2'd0;
                        if (b[6:0] <= LEN7_MAX) begin
                            pr_len = {57'd0, b[6:0]};
                            pr_phase = PH_KEY;
                        end else begin
                            pr_len = 64'd0;
                            pr_len_left = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                            pr_phase = PH_LEN_EXT;
                        end
                    end
                end
                PH_LEN_EXT: begin
                    pr_len = {pr_len[55:0], b};
                    if (pr_len_left != 4'd0) pr_len_left = pr_len_left - 4'd1;
                    if (pr_len_left == 4'd0) begin
                        if (pr_len[63]) err = ERR_LEN_BIG;
                        else pr_phase = PH_KEY;
                    end
                end
                PH_KEY: begin
                    pr_key[pr_key_idx] = b;
                    pr_key_idx = pr_key_idx + 2'd1;
                    if (pr_key_idx == 2'd0) begin
                        if (pr_len == 64'd0) begin
                            last = 1'b1;
                            close_frame();
                        end else begin
                            pr_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    kind = KIND_PAYLOAD;
                    data = b ^ pr_key[pr_key_idx];
                    pr_key_idx = pr_key_idx + 2'd1;
                    pr_done = pr_done + 64'd1;
                    if (pr_done >= pr_len) begin
                        last = 1'b1;
                        close_frame();
                    end
                end
                default: pr_phase = PH_OPCODE;
            endcase
        end
        if (err != ERR_NONE) begin
            pr_halted = 1'b1;
            kind = KIND_ERROR;
        end
        r.kind = kind;
        r.data = data;
        r.opcode = pr_opcode;
        r.fin = pr_fin;
        r.last = last;
        r.err = err;
        return r;
    endfunction

    function automatic logic [3:0] pick_start_op();
        case ($urandom_range(4))
            0: return OP_TEXT;
            1: return OP_BINARY;
            2: return OP_CLOSE;
            3: return OP_PING;
            default: return OP_PONG;
        endcase
    endfunction

    // one masked frame; enc 0 is the 7-bit length, 1 the 16-bit, 2 the 64-bit
    // with fixed set, the key bytes are pat and the payload bytes its inverse
    task automatic push_frame(input logic [3:0] op, input logic fin, input logic [63:0] len,
                              input int enc, input bit fixed, input logic [7:0] pat);
        logic [2:0] junk;
        junk = 3'($urandom_range(7));
        stream_bytes.push_back({fin, junk, op});
        if (enc == 0) begin
            stream_bytes.push_back({1'b1, len[6:0]});
        end else if (enc == 1) begin
            stream_bytes.push_back({1'b1, LEN7_EXT16});
            stream_bytes.push_back(len[15:8]);
            stream_bytes.push_back(len[7:0]);
        end else begin
            stream_bytes.push_back(8'hFF);
            for (int i = 7; i >= 0; i--) stream_bytes.push_back(len[8*i +: 8]);
        end
        for (int i = 0; i < 4; i++) stream_bytes.push_back(fixed ? pat : 8'($urandom));
        for (longint i = 0; i < longint'(len); i++) begin
            stream_bytes.push_back(fixed ? ~pat : 8'($urandom));
        end
    endtask

    // random frame length, mostly short, with the encoding boundaries now and then
    task automatic pick_length(output logic [63:0] len, output int enc);
        int r;
        r = $urandom_range(99);
        enc = 0;
        if (r < 60) begin
            len = 64'($urandom_range(20));
        end else if (r < 78) begin
            len = 64'($urandom_range(125, 21));
        end else if (r < 86) begin
            len = 64'($urandom_range(300));
            enc = 1;
        end else if (r < 93) begin
            len = 64'($urandom_range(40));
            enc = 2;
        end else if (r < 96) begin
            len = 64'd125;
        end else begin
            len = 64'd126;
            enc = 1;
        end
    endtask

    // a whole message: one final frame, or a start frame and its continuations
    task automatic push_message();
        logic [3:0]  op;
        logic [63:0] len;
        int          enc;
        int          n_cont;
        op = pick_start_op();
        pick_length(len, enc);
        if ($urandom_range(99) < 65) begin
            push_frame(op, 1'b1, len, enc, 1'b0, 8'h00);
        end else begin
            push_frame(op, 1'b0, len, enc, 1'b0, 8'h00);
            n_cont = $urandom_range(3);
            for (int i = 0; i < n_cont; i++) begin
                pick_length(len, enc);
                push_frame(OP_CONT, 1'b0, len, enc, 1'b0, 8'h00);
            end
            pick_length(len, enc);
            push_frame(OP_CONT, 1'b1, len, enc, 1'b0, 8'h00);
        end
    endtask

    // the stream ends in one protocol error and halted bytes, or in a huge frame
    task automatic push_tail();
        int          sel;
        int          r;
        logic [63:0] len;
        logic [2:0]  junk;
        sel = $urandom_range(5);
        junk = 3'($urandom_range(7));
        case (sel)
            0: begin
                len = {2'b01, 30'($urandom), 32'($urandom)};
                stream_bytes.push_back({1'b1, junk, OP_BINARY});
                stream_bytes.push_back(8'hFF);
                for (int i = 7; i >= 0; i--) stream_bytes.push_back(len[8*i +: 8]);
                for (int i = 0; i < 34; i++) stream_bytes.push_back(8'($urandom));
            end
            1: stream_bytes.push_back({1'($urandom), junk, OP_CONT});
            2: begin
                push_frame(pick_start_op(), 1'b0, 64'($urandom_range(5)), 0, 1'b0, 8'h00);
                stream_bytes.push_back({1'($urandom), junk, pick_start_op()});
            end
            3: begin
                r = $urandom_range(9);
                stream_bytes.push_back({1'($urandom), junk, (r < 5) ? 4'(3 + r) : 4'(6 + r)});
            end
            4: begin
                stream_bytes.push_back({1'b1, junk, pick_start_op()});
                stream_bytes.push_back({1'b0, 7'($urandom)});
            end
            default: begin
                stream_bytes.push_back({1'b1, junk, pick_start_op()});
                stream_bytes.push_back(8'hFF);
                stream_bytes.push_back({1'b1, 7'($urandom)});
                for (int i = 0; i < 7; i++) stream_bytes.push_back(8'($urandom));
            end
        endcase
        if (sel != 0) begin
            for (int i = 0; i < 20; i++) stream_bytes.push_back(8'($urandom));
        end
    endtask

    // stimulus, reset and end of run
    initial begin
        int n_directed;
        // zero-length frames, fragmented message, all three length encodings
        push_frame(OP_PING, 1'b1, 64'd0, 0, 1'b1, 8'h00);
        push_frame(OP_TEXT, 1'b0, 64'd2, 0, 1'b1, 8'h00);
        push_frame(OP_CONT, 1'b0, 64'd1, 0, 1'b1, 8'hFF);
        push_frame(OP_CONT, 1'b1, 64'd0, 1, 1'b0, 8'h00);
        push_frame(OP_BINARY, 1'b1, 64'd1, 2, 1'b0, 8'h00);
        push_frame(OP_CLOSE, 1'b1, 64'd0, 2, 1'b0, 8'h00);
        push_frame(OP_PONG, 1'b1, 64'd1, 0, 1'b1, 8'hFF);
        n_directed = stream_bytes.size();
        while (stream_bytes.size() < n_directed + RANDOM_BYTES) push_message();
        push_tail();
        n_total = stream_bytes.size();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (n_sent < n_total || expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_fail == 0) begin
            $display("tb_websocket_frame_deframer_unit: clean");
        end else begin
            $display("tb_websocket_frame_deframer_unit: errors");
        end
        $finish;
    end

    // driver: new transaction or idle on the falling edge, random backpressure
    always @(negedge aclk) begin : driver_p
        int src_idle;
        int snk_idle;
        if (n_sent * 3 < n_total) begin
            src_idle = 34;
            snk_idle = 81;
        end else if (n_sent * 3 < 2 * n_total) begin
            src_idle = 81;
            snk_idle = 34;
        end else begin
            src_idle = 0;
            snk_idle = 0;
        end
        if (aresetn) begin
            if (!s_valid || s_fire) begin
                if (stream_bytes.size() != 0 && $urandom_range(99) >= src_idle) begin
                    s_valid <= 1'b1;
                    s_byte_in <= stream_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    // monitor: predict on each accepted byte, check each accepted result
    always @(posedge aclk) begin : monitor_p
        deframe_result_t exp_r;
        s_fire <= s_valid && s_ready && aresetn;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(deframe_byte(s_byte_in));
                n_sent++;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: kind %0d", m_kind);
                    n_fail++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_kind !== exp_r.kind) begin
                        $error("kind: expected %0d, got %0d", exp_r.kind, m_kind);
                        n_fail++;
                    end
                    if (m_data_out !== exp_r.data) begin
                        $error("data_out: expected %0h, got %0h", exp_r.data, m_data_out);
                        n_fail++;
                    end
                    if (m_frame_opcode !== exp_r.opcode) begin
                        $error("frame_opcode: expected %0d, got %0d",
                               exp_r.opcode, m_frame_opcode);
                        n_fail++;
                    end
                    if (m_message_final !== exp_r.fin) begin
                        $error("message_final: expected %0d, got %0d",
                               exp_r.fin, m_message_final);
                        n_fail++;
                    end
                    if (m_last_of_frame !== exp_r.last) begin
                        $error("last_of_frame: expected %0d, got %0d",
                               exp_r.last, m_last_of_frame);
                        n_fail++;
                    end
                    if (m_error_code !== exp_r.err) begin
                        $error("error_code: expected %0d, got %0d", exp_r.err, m_error_code);
                        n_fail++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_websocket_frame_deframer_unit: errors");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
design/wsdf_pkg.sv
design/wsdf_front.sv
design/wsdf_queue.sv
design/wsdf_back.sv
design/websocket_frame_deframer_unit.sv
bench/tb_websocket_frame_deframer_unit.sv
